@@ rtl/dst_pkg.sv @@
package dst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int DATE_W = 23;
    localparam int CODE_W = 40;
    localparam int REC_W = 16;
    localparam int ENTRY_W = DATE_W + CODE_W + REC_W;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_RANGE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_READ,
        S_INS_CHECK,
        S_INS_SHIFT,
        S_FIND_READ,
        S_FIND_CHECK,
        S_DEL_READ,
        S_DEL_SHIFT,
        S_RNG_READ,
        S_RNG_CHECK,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_req;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic              wr_new;
        logic              emit;
        logic [2:0]        emit_status;
        logic              emit_entry;
        logic              emit_last;
        logic              flush;
        logic              set_last;
        logic              cnt_inc;
        logic              cnt_dec;
    } dst_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        kind_t             kind;
        logic [CNT_W-1:0]  count;
        logic              code_match;
        logic              date_gt_new;
        logic              in_range;
        logic              out_busy;
        logic              out_free;
    } dst_sts_t;

    function automatic logic [DATE_W-1:0] pack_date(logic [4:0] d, logic [3:0] m,
                                                    logic [13:0] y);
        return {y, m, d};
    endfunction

endpackage

@@ rtl/dst_ctrl.sv @@
module dst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dst_pkg::dst_sts_t sts,
    output dst_pkg::dst_cmd_t cmd
);
    import dst_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W:0]   i_reg, i_next;
    logic [IDX_W:0]   j_reg, j_next;
    logic [IDX_W:0]   w_reg, w_next;
    logic             hit_reg, hit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            w_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            w_reg <= w_next;
            hit_reg <= hit_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        w_next = w_reg;
        hit_next = hit_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                i_next = '0;
                w_next = '0;
                hit_next = 1'b0;
                if (sts.kind == KIND_INSERT) begin
                    if (sts.count >= CNT_W'(CAPACITY)) begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = ST_FULL;
                        cmd.emit_last = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_INS_READ;
                    end
                end else if (sts.count == '0) begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    cmd.emit_last = 1'b1;
                    state_next = S_OUT;
                end else if (sts.kind == KIND_RANGE) begin
                    state_next = S_RNG_READ;
                end else begin
                    state_next = S_FIND_READ;
                end
            end
            // Insert: find the slot, then shift the tail down one at a time.
            S_INS_READ: begin
                if (i_reg == sts.count) begin
                    j_next = sts.count;
                    state_next = S_INS_SHIFT;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                    state_next = S_INS_CHECK;
                end
            end
            S_INS_CHECK: begin
                if (sts.date_gt_new) begin
                    i_next = i_reg + 1'b1;
                    state_next = S_INS_READ;
                end else begin
                    j_next = sts.count;
                    state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (j_reg == i_reg) begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = i_reg[IDX_W-1:0];
                    cmd.wr_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_INSERTED;
                    cmd.emit_last = 1'b1;
                    state_next = S_OUT;
                end else if (hit_reg) begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = j_reg[IDX_W-1:0];
                    hit_next = 1'b0;
                    j_next = j_reg - 1'b1;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = IDX_W'(j_reg - 1'b1);
                    hit_next = 1'b1;
                end
            end
            // Find and delete share the scan.
            S_FIND_READ: begin
                if (i_reg == sts.count) begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    cmd.emit_last = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                    state_next = S_FIND_CHECK;
                end
            end
            S_FIND_CHECK: begin
                if (sts.code_match) begin
                    cmd.emit = 1'b1;
                    cmd.emit_entry = 1'b1;
                    cmd.emit_last = 1'b1;
                    if (sts.kind == KIND_FIND) begin
                        cmd.emit_status = ST_FOUND;
                        state_next = S_OUT;
                    end else begin
                        cmd.emit_status = ST_REMOVED;
                        cmd.cnt_dec = 1'b1;
                        j_next = i_reg;
                        state_next = S_DEL_READ;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    state_next = S_FIND_READ;
                end
            end
            // Count already dropped: close the gap up to the new count.
            S_DEL_READ: begin
                if (j_reg == sts.count) begin
                    state_next = S_OUT;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = IDX_W'(j_reg + 1'b1);
                    state_next = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT: begin
                cmd.wr_en = 1'b1;
                cmd.wr_addr = j_reg[IDX_W-1:0];
                j_next = j_reg + 1'b1;
                state_next = S_DEL_READ;
            end
            // Range delete: compact in place, emit each removed entry.
            // The scan ends once every entry held at the start has been read.
            S_RNG_READ: begin
                if (i_reg == sts.count + (i_reg - w_reg)) begin
                    if (!hit_reg) begin
                        cmd.emit = 1'b1;
                        cmd.emit_status = ST_NOT_FOUND;
                        cmd.emit_last = 1'b1;
                    end else begin
                        cmd.set_last = 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                    state_next = S_RNG_CHECK;
                end
            end
            // A removal that follows another waits until the held one can move out.
            S_RNG_CHECK: begin
                if (sts.in_range) begin
                    if (!hit_reg || sts.out_free) begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RNG_READ;
                        hit_next = 1'b1;
                        cmd.flush = hit_reg;
                        cmd.cnt_dec = 1'b1;
                        cmd.emit = 1'b1;
                        cmd.emit_entry = 1'b1;
                        cmd.emit_status = ST_REMOVED;
                        cmd.emit_last = 1'b0;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    state_next = S_RNG_READ;
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = w_reg[IDX_W-1:0];
                    w_next = w_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/dst_datapath.sv @@
module dst_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [1:0]                 in_kind,
    input  logic [dst_pkg::CODE_W-1:0] in_code,
    input  logic [dst_pkg::DATE_W-1:0] in_new_date,
    input  logic [dst_pkg::REC_W-1:0]  in_record,
    input  logic [dst_pkg::DATE_W-1:0] in_lo_date,
    input  logic [dst_pkg::DATE_W-1:0] in_hi_date,
    input  dst_pkg::dst_cmd_t          cmd,
    output dst_pkg::dst_sts_t          sts,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [95:0]                m_tdata,
    output logic                       m_tlast
);
    import dst_pkg::*;

    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rd_reg;
    logic [1:0]         kind_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [DATE_W-1:0]  new_reg, lo_reg, hi_reg;
    logic [REC_W-1:0]   rec_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic               pend_reg, pend_next;
    logic [2:0]         pst_reg;
    logic               pent_reg, plast_reg;
    logic [ENTRY_W-1:0] pdata_reg;
    logic               ov_reg;
    logic [95:0]        od_reg;
    logic               ol_reg;
    logic [DATE_W-1:0]  rd_date;
    logic [CODE_W-1:0]  rd_code;
    logic [REC_W-1:0]   rd_rec;
    logic               ov_free;
    logic               move;

    assign {rd_date, rd_code, rd_rec} = rd_reg;

    // Request fields latched on accept.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            kind_reg <= in_kind;
            code_reg <= in_code;
            new_reg <= in_new_date;
            rec_reg <= in_record;
            lo_reg <= in_lo_date;
            hi_reg <= in_hi_date;
        end
    end

    // Entry store, one read and one write port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_new ? {new_reg, code_reg, rec_reg} : rd_reg;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[cmd.rd_addr];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc) cnt_next = cnt_reg + 1'b1;
        if (cmd.cnt_dec) cnt_next = cnt_reg - 1'b1;
    end

    // One pending result waits for the output register. A range removal is held
    // there until the next removal or the end of the scan shows whether it is last.
    assign ov_free = !ov_reg || m_tready;
    assign move = pend_reg && ov_free && (plast_reg || cmd.flush);

    always_comb begin
        pend_next = pend_reg;
        held_next = held_reg;
        if (move) pend_next = 1'b0;
        if (cmd.emit) begin
            pend_next = 1'b1;
            held_next = cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            pend_reg <= pend_next;
            if (ov_free) ov_reg <= move;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (cmd.emit) begin
            pst_reg <= cmd.emit_status;
            pent_reg <= cmd.emit_entry;
            plast_reg <= cmd.emit_last;
            pdata_reg <= rd_reg;
        end else if (cmd.set_last) begin
            plast_reg <= 1'b1;
        end
        if (move) begin
            od_reg <= {7'd0, held_reg,
                       pent_reg ? pdata_reg[REC_W-1:0] : 16'd0,
                       pent_reg ? pdata_reg[ENTRY_W-1 -: DATE_W] : 23'd0,
                       pent_reg ? pdata_reg[REC_W +: CODE_W] : 40'd0,
                       pst_reg};
            ol_reg <= plast_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;
    assign m_tlast = ol_reg;

    assign sts.kind = kind_t'(kind_reg);
    assign sts.count = cnt_reg;
    assign sts.code_match = rd_code == code_reg;
    assign sts.date_gt_new = rd_date > new_reg;
    assign sts.in_range = rd_date > lo_reg && rd_date < hi_reg;
    assign sts.out_busy = pend_reg;
    assign sts.out_free = ov_free;

endmodule

@@ rtl/date_sorted_table_top.sv @@
// Date-sorted table: up to 64 entries held newest first.
// Requests enter on the s_ stream; tuser carries the kind (0 insert,
// 1 find, 2 delete by code, 3 delete date range) and tdata the other fields.
// Results leave on the m_ stream, one per request except range delete, which
// gives one per removed entry, or a single result when none is removed; m_tlast
// marks the final result of a request. One request is handled at a time. Insert
// scans to its slot and shifts the tail; find scans entry by entry, delete also
// shifts every entry behind the match, and range delete reads every entry and
// can wait on receiver stalls. Every request passes an accept state and a
// dispatch state, and each result passes one output register.
// A receiver stall holds the output register; a range scan pauses at its next
// removal while one removal waits; nothing is dropped. Reset empties the table
// at once; no clearing pass is needed.
module date_sorted_table_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low bit up: code, birth_day, birth_month, birth_year, record_id,
    // after_day, after_month, after_year, before_day, before_month, before_year
    input  logic [127:0] s_tdata,
    // tuser: kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, low bit up: status, found_code, found_day, found_month,
    // found_year, found_record, entries_held, zero fill
    output logic [95:0]  m_tdata,
    output logic         m_tlast
);
    import dst_pkg::*;

    dst_cmd_t cmd;
    dst_sts_t sts;

    dst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dst_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_kind     (s_tuser),
        .in_code     (s_tdata[39:0]),
        .in_new_date (pack_date(s_tdata[44:40], s_tdata[48:45], s_tdata[62:49])),
        .in_record   (s_tdata[78:63]),
        .in_lo_date  (pack_date(s_tdata[83:79], s_tdata[87:84], s_tdata[101:88])),
        .in_hi_date  (pack_date(s_tdata[106:102], s_tdata[110:107], s_tdata[124:111])),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    // The table never holds more than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A new request is never taken while a result still waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.out_busy)
        else $error("request accepted with result pending");

    // Count changes only by one step at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count incremented and decremented together");
`endif

endmodule
